[rtl/imufdf_pkg.sv]
// ----------------------------------------------------------------------------
// imufdf_pkg
// shared constants, register indexes and handoff types of the imu deframer
// ----------------------------------------------------------------------------
`default_nettype none

package imufdf_pkg;

    // parameter defaults
    localparam int SYNC_ZEROS_DEF = 5;
    localparam int FRAC_BITS_DEF  = 16;

    // frame layout
    localparam int FRAME_LEN  = 22;
    localparam int STORE_LEN  = 18;
    localparam int IDX_W      = 5;
    localparam int ZR_W       = 3;
    localparam int GYRO_LSB   = 10;
    localparam int GYRO_MSB   = 25;
    localparam int ACC_SHIFT  = 2;

    // channel layout: accel a/b/c then gyro x/y/z
    localparam int NCH        = 6;
    localparam int NACC       = 3;
    localparam int SMP_W      = 17;
    localparam int STATE_W    = 32;
    localparam int OFF_W      = 16;
    localparam int RATIO_W    = 17;
    localparam int RATIO_FRAC = 16;
    localparam int ROUND_HALF = 32768;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 17;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ACC_RATIO  = 3'd0,
        CFG_GYRO_RATIO = 3'd1,
        CFG_OFFSET_X   = 3'd2,
        CFG_OFFSET_Y   = 3'd3,
        CFG_OFFSET_Z   = 3'd4,
        CFG_INVERT_GY  = 3'd5
    } t_cfg_idx;

    // decode controls handed to the deframer
    typedef struct packed {
        logic [NACC-1:0][OFF_W-1:0] offset;
        logic                       invert_gy;
    } t_dec_cfg;

    // one finished frame: trailer flag and six decoded samples
    typedef struct packed {
        logic                      dirty;
        logic [NCH-1:0][SMP_W-1:0] smp;
    } t_frame_evt;

endpackage

`default_nettype wire

[rtl/imufdf_deframe.sv]
// ----------------------------------------------------------------------------
// imufdf_deframe
// sync hunt, frame capture, trailer check and sample decode
// ----------------------------------------------------------------------------
`default_nettype none

module imufdf_deframe #(
    parameter int SYNC_ZEROS = imufdf_pkg::SYNC_ZEROS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_byte,
    input  imufdf_pkg::t_dec_cfg   i_cfg,
    input  logic                   i_take,
    output logic                   o_ready,
    output logic                   o_evt_valid,
    output imufdf_pkg::t_frame_evt o_evt
);
    import imufdf_pkg::*;

    logic             r_in_frame, n_in_frame;
    logic [ZR_W-1:0]  r_zr, n_zr;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_clean, n_clean;
    logic [7:0]       r_store [STORE_LEN];
    logic             r_evt_valid;
    t_frame_evt       r_evt, n_evt;
    logic             fire;
    logic             evt_dirty;
    logic [ZR_W-1:0]  zr_cnt;

    assign o_ready     = !r_evt_valid || i_take;
    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

    // hunt / capture control
    always_comb begin
        n_in_frame = r_in_frame;
        n_zr       = r_zr;
        n_idx      = r_idx;
        n_clean    = r_clean;
        fire       = 1'b0;
        zr_cnt     = r_zr;
        evt_dirty  = 1'b0;
        if (i_valid) begin
            if (!r_in_frame) begin
                if (i_byte != 8'd0) begin
                    zr_cnt = '0;
                end else if (r_zr != '1) begin
                    zr_cnt = r_zr + 1'b1;
                end
                if (zr_cnt >= ZR_W'(SYNC_ZEROS)) begin
                    n_in_frame = 1'b1;
                    n_zr       = '0;
                    n_idx      = '0;
                    n_clean    = 1'b1;
                end else begin
                    n_zr = zr_cnt;
                end
            end else if (r_idx == IDX_W'(FRAME_LEN - 1)) begin
                fire      = 1'b1;
                evt_dirty = !r_clean || (i_byte != 8'd0);
                n_idx     = '0;
                n_clean   = 1'b1;
                if (evt_dirty) begin
                    n_in_frame = 1'b0;
                    n_zr       = '0;
                end
            end else begin
                n_idx = r_idx + 1'b1;
                if (r_idx >= IDX_W'(STORE_LEN) && i_byte != 8'd0) begin
                    n_clean = 1'b0;
                end
            end
        end
    end

    // sample decode from the captured bytes
    always_comb begin
        logic [31:0]      gw;
        logic [15:0]      g16;
        logic [SMP_W-1:0] gext;
        logic [SMP_W-1:0] aw;
        gw   = '0;
        g16  = '0;
        gext = '0;
        aw   = '0;
        n_evt.dirty = evt_dirty;
        n_evt.smp   = '0;
        for (int k = 0; k < NACC; k++) begin
            aw = {1'b0, r_store[12 + 2*k], r_store[13 + 2*k]} - {1'b0, i_cfg.offset[k]};
            n_evt.smp[k] = SMP_W'($signed(aw) >>> ACC_SHIFT);
        end
        for (int k = 0; k < NCH - NACC; k++) begin
            gw   = {r_store[4*k], r_store[4*k + 1], r_store[4*k + 2], r_store[4*k + 3]};
            g16  = gw[GYRO_MSB:GYRO_LSB];
            gext = {g16[15], g16};
            // y gyro may be negated; full-scale negative becomes +32768
            if (k == 1 && i_cfg.invert_gy) begin
                gext = -gext;
            end
            n_evt.smp[NACC + k] = gext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_zr        <= '0;
            r_idx       <= '0;
            r_clean     <= 1'b1;
            r_evt_valid <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_zr       <= n_zr;
            r_idx      <= n_idx;
            r_clean    <= n_clean;
            if (fire) begin
                r_evt_valid <= 1'b1;
            end else if (i_take) begin
                r_evt_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && r_in_frame && r_idx < IDX_W'(STORE_LEN)) begin
            r_store[r_idx] <= i_byte;
        end
        if (fire) begin
            r_evt <= n_evt;
        end
    end

    a_hunt_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_idx == '0)
        else $error("byte index nonzero while hunting");

    a_evt_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evt_valid && !i_take) |=> (r_evt_valid && $stable(r_evt)))
        else $error("pending frame event lost or changed");

endmodule

`default_nettype wire

[rtl/imufdf_filt.sv]
// ----------------------------------------------------------------------------
// imufdf_filt
// one first-order exponential filter channel with its state register
// ----------------------------------------------------------------------------
`default_nettype none

module imufdf_filt #(
    parameter int FRAC_BITS = imufdf_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_upd,
    input  logic signed [imufdf_pkg::SMP_W-1:0]   i_sample,
    input  logic [imufdf_pkg::RATIO_W-1:0]        i_ratio,
    output logic signed [imufdf_pkg::STATE_W-1:0] o_next
);
    import imufdf_pkg::*;

    localparam int SHW  = (SMP_W + FRAC_BITS > STATE_W + 1) ? SMP_W + FRAC_BITS : STATE_W + 1;
    localparam int DW   = STATE_W + 1;
    localparam int PW   = DW + RATIO_W + 1;
    localparam logic signed [SHW-1:0] MAXV = {{(SHW - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
    localparam logic signed [SHW-1:0] MINV = {{(SHW - STATE_W + 1){1'b1}}, {(STATE_W - 1){1'b0}}};

    logic signed [STATE_W-1:0] r_state;
    logic signed [SHW-1:0]     sh;
    logic signed [STATE_W-1:0] s;
    logic [RATIO_W-1:0]        r_sat;
    logic signed [DW-1:0]      diff;
    logic signed [PW-1:0]      prod;
    logic signed [PW-1:0]      acc;
    logic signed [PW-1:0]      delta;

    // sample to fixed point, saturated to the state width
    always_comb begin
        sh = SHW'(i_sample) <<< FRAC_BITS;
        if (sh > MAXV) begin
            s = MAXV[STATE_W-1:0];
        end else if (sh < MINV) begin
            s = MINV[STATE_W-1:0];
        end else begin
            s = sh[STATE_W-1:0];
        end
    end

    // old + round((s - old) * r / 2^16); the result stays between old and s
    always_comb begin
        r_sat = (i_ratio > RATIO_ONE) ? RATIO_ONE : i_ratio;
        diff  = DW'(s) - DW'(r_state);
        prod  = PW'(diff) * PW'($signed({1'b0, r_sat}));
        acc   = prod + PW'(ROUND_HALF);
        delta = acc >>> RATIO_FRAC;
        o_next = r_state + delta[STATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_upd) begin
            r_state <= o_next;
        end
    end

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_upd |=> $stable(r_state))
        else $error("filter state moved without an update");

endmodule

`default_nettype wire

[rtl/imu_frame_deframe_filter_core.sv]
// ----------------------------------------------------------------------------
// imu_frame_deframe_filter_core
// imu serial deframer with six exponential filters on gyro and accel samples
// ----------------------------------------------------------------------------
// path: the result of a frame's last byte beat passes the event register,
//   then the output register, before its result beat can be taken
// throughput: one byte beat per cycle; the input stalls only while a frame
//   result waits in the event stage behind an unread output beat
// reset: synchronous active low; hunting for sync, filter states zero,
//   ratios at one (no smoothing), offsets zero, y gyro not inverted
// ----------------------------------------------------------------------------
`default_nettype none

module imu_frame_deframe_filter_core #(
    parameter int SYNC_ZEROS = imufdf_pkg::SYNC_ZEROS_DEF,
    parameter int FRAC_BITS  = imufdf_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // rx_byte
    // result stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // filt_acc_a, filt_acc_b, filt_acc_c, filt_gyro_x, filt_gyro_y, filt_gyro_z
    output logic [191:0]                   m_axis_tdata,
    output logic                           m_axis_tuser,   // frame_status
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [imufdf_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [imufdf_pkg::CFG_DW-1:0]  i_cfg_data
);
    import imufdf_pkg::*;

    // configuration registers
    logic [RATIO_W-1:0] r_acc_ratio;
    logic [RATIO_W-1:0] r_gyro_ratio;
    t_dec_cfg           r_dec_cfg;

    // event stage and output register
    logic                           evt_valid;
    t_frame_evt                     evt;
    logic                           take;
    logic                           r_out_valid;
    logic                           r_out_status;
    logic [NCH-1:0][STATE_W-1:0]    r_out_data;
    logic [NCH-1:0][STATE_W-1:0]    next_st;
    logic                           in_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_ratio         <= RATIO_ONE;
            r_gyro_ratio        <= RATIO_ONE;
            r_dec_cfg.offset    <= '0;
            r_dec_cfg.invert_gy <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ACC_RATIO:  r_acc_ratio         <= i_cfg_data;
                CFG_GYRO_RATIO: r_gyro_ratio        <= i_cfg_data;
                CFG_OFFSET_X:   r_dec_cfg.offset[0] <= i_cfg_data[OFF_W-1:0];
                CFG_OFFSET_Y:   r_dec_cfg.offset[1] <= i_cfg_data[OFF_W-1:0];
                CFG_OFFSET_Z:   r_dec_cfg.offset[2] <= i_cfg_data[OFF_W-1:0];
                CFG_INVERT_GY:  r_dec_cfg.invert_gy <= i_cfg_data[0];
                default: ;   // unused indexes are dropped
            endcase
        end
    end

    // a frame event moves on when the output register is free or being read
    assign take    = evt_valid && (!r_out_valid || m_axis_tready);
    assign in_beat = s_axis_tvalid && s_axis_tready;

    imufdf_deframe #(
        .SYNC_ZEROS (SYNC_ZEROS)
    ) u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_beat),
        .i_byte      (s_axis_tdata),
        .i_cfg       (r_dec_cfg),
        .i_take      (take),
        .o_ready     (s_axis_tready),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    // six filter channels; states update only on clean frames
    for (genvar k = 0; k < NCH; k++) begin : g_ch
        imufdf_filt #(
            .FRAC_BITS (FRAC_BITS)
        ) u_filt (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_upd    (take && !evt.dirty),
            .i_sample ($signed(evt.smp[k])),
            .i_ratio  ((k < NACC) ? r_acc_ratio : r_gyro_ratio),
            .o_next   (next_st[k])
        );
    end

    // output register; a dirty trailer reports status only with zero data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_status <= evt.dirty;
            r_out_data   <= evt.dirty ? '0 : next_st;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = r_out_data;

    a_dirty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> r_out_data == '0)
        else $error("resync beat carries filter data");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (evt_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("byte beat taken while a frame result is stuck");

endmodule

`default_nettype wire

[verif/imu_frame_deframe_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// imu_frame_deframe_filter_core_tb
// self-checking bench for the imu deframer and its six exponential filters:
// a table of hand-built frames with fixed-value checks on the obvious rows,
// then random frame streams under several register settings, every result
// beat checked field by field against a bit-exact behavioral predictor
// ----------------------------------------------------------------------------
`default_nettype none

module imu_frame_deframe_filter_core_tb;

    import imufdf_pkg::*;

    localparam int SYNC_RUN      = SYNC_ZEROS_DEF;
    localparam int SETTLE_CYCLES = 6;        // results pass the event and output registers, keep some margin
    localparam int CYCLE_LIMIT   = 300000;
    localparam int N_DIR         = 13;
    localparam int N_PHASES      = 8;
    localparam int PHASE_BYTES   = 130;

    // addresses past the register list, writes there must be dropped
    localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;

    // what precedes a frame in the directed table
    typedef enum logic [1:0] {
        LEAD_NONE,   // frame follows the previous clean frame directly
        LEAD_SYNC,   // plain sync run
        LEAD_NOISY   // broken zero run, then a sync run
    } t_lead;

    typedef struct packed {
        logic [RATIO_W-1:0] acc_ratio;
        logic [RATIO_W-1:0] gyro_ratio;
        logic [OFF_W-1:0]   off_x;
        logic [OFF_W-1:0]   off_y;
        logic [OFF_W-1:0]   off_z;
        logic               inv_gy;
    } t_reg_set;

    typedef struct packed {
        logic        status;
        logic [31:0] acc_a;
        logic [31:0] acc_b;
        logic [31:0] acc_c;
        logic [31:0] gyro_x;
        logic [31:0] gyro_y;
        logic [31:0] gyro_z;
    } t_imu_result;

    typedef struct packed {
        logic        on;
        t_imu_result res;
    } t_fixed_res;

    typedef struct packed {
        t_lead                     lead;
        logic                      cfg_en;
        t_reg_set                  regs;
        logic [0:STORE_LEN-1][7:0] payload;
        logic [0:3][7:0]           trailer;
        logic                      has_exp;
        t_imu_result               exp_res;
    } t_frame_row;

    localparam t_reg_set RESET_REGS = '{17'h10000, 17'h10000, 16'h0000, 16'h0000, 16'h0000, 1'b0};
    localparam t_imu_result NO_RES    = '0;
    localparam t_imu_result DIRTY_RES = '{1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};

    // gyro x max, gyro y min, gyro z zero with all ignored word bits set,
    // accel full scale, zero and mid scale
    localparam logic [0:STORE_LEN-1][7:0] P_EXT =
        144'h01FFFC00_02000000_FC0003FF_FFFF_0000_8000;

    // directed frames, ratio one makes the output equal the scaled sample
    localparam t_frame_row DIR_ROWS [N_DIR] = '{
        // all zero frame right after reset
        '{LEAD_SYNC, 1'b0, RESET_REGS, 144'h0, 32'h0, 1'b1,
          '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
        // field extremes, back to back
        '{LEAD_NONE, 1'b0, RESET_REGS, P_EXT, 32'h0, 1'b1,
          '{1'b0, 32'h3FFF0000, 32'h0, 32'h20000000, 32'h7FFF0000, 32'h80000000, 32'h0}},
        // dirty last trailer byte
        '{LEAD_NONE, 1'b0, RESET_REGS, P_EXT, 32'h00000001, 1'b1, DIRTY_RES},
        // nonzero byte breaks the zero run while hunting
        '{LEAD_NOISY, 1'b0, RESET_REGS, 144'h12345678_9ABCDEF0_0FEDCBA9_8765_4321_A55A,
          32'h0, 1'b0, NO_RES},
        // y gyro min inverted saturates, offset extremes
        '{LEAD_NONE, 1'b1, '{17'h10000, 17'h10000, 16'hFFFF, 16'h0000, 16'h8000, 1'b1},
          144'h00000000_02000000_01FFFC00_0000_FFFF_8000, 32'h0, 1'b1,
          '{1'b0, 32'hC0000000, 32'h3FFF0000, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h7FFF0000}},
        // ratios above one saturate to one
        '{LEAD_NONE, 1'b1, '{17'h1FFFF, 17'h1FFFF, 16'h1234, 16'hABCD, 16'h0FF0, 1'b0},
          {STORE_LEN{8'hFF}}, 32'h0, 1'b0, NO_RES},
        // ratio zero holds the filter state
        '{LEAD_NONE, 1'b1, '{17'h00000, 17'h00000, 16'h1234, 16'hABCD, 16'h0FF0, 1'b1},
          P_EXT, 32'h0, 1'b0, NO_RES},
        // fractional ratios
        '{LEAD_NONE, 1'b1, '{17'h08000, 17'h04000, 16'h0100, 16'h0200, 16'hFFFF, 1'b1},
          144'h00C3A500_03FFFC00_80000400_7FFF_8001_0001, 32'h0, 1'b0, NO_RES},
        // dirty first trailer byte, the three zeros after it must not count as sync
        '{LEAD_NONE, 1'b0, RESET_REGS, 144'h5A5A5A5A_A5A5A5A5_3C3C3C3C_C3C3_0F0F_F0F0,
          32'hFF000000, 1'b1, DIRTY_RES},
        '{LEAD_SYNC, 1'b0, RESET_REGS, 144'h00000400_0000FC00_01000000_1000_2000_3000,
          32'h0, 1'b0, NO_RES},
        '{LEAD_NONE, 1'b0, RESET_REGS, P_EXT, 32'h00008000, 1'b1, DIRTY_RES},
        '{LEAD_NOISY, 1'b0, RESET_REGS, 144'h0055AA00_FF00FF00_00FF00FF_AA55_55AA_0102,
          32'h0, 1'b0, NO_RES},
        // back to reset settings, all positive extremes
        '{LEAD_NONE, 1'b1, RESET_REGS, 144'h01FFFC00_01FFFC00_01FFFC00_FFFF_FFFF_FFFF,
          32'h0, 1'b1,
          '{1'b0, 32'h3FFF0000, 32'h3FFF0000, 32'h3FFF0000,
            32'h7FFF0000, 32'h7FFF0000, 32'h7FFF0000}}
    };

    // dut ports, all driven from time zero
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = 8'h00;   // rx_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // filt_acc_a, filt_acc_b, filt_acc_c, filt_gyro_x, filt_gyro_y, filt_gyro_z
    logic [191:0]        m_axis_tdata;
    logic                m_axis_tuser;            // frame_status
    logic                i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr    = '0;
    logic [CFG_DW-1:0]   i_cfg_data    = '0;

    imu_frame_deframe_filter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // bytes waiting to go out, expected frame results, fixed values from the table
    logic [7:0]  stim_bytes [$];
    t_imu_result expected_frames [$];
    t_fixed_res  fixed_q [$];
    int          fail_count  = 0;
    int          cycle_count = 0;

    // predictor copy of the registers
    logic [RATIO_W-1:0] acc_ratio_q  = RATIO_ONE;
    logic [RATIO_W-1:0] gyro_ratio_q = RATIO_ONE;
    logic [OFF_W-1:0]   off_x_q      = '0;
    logic [OFF_W-1:0]   off_y_q      = '0;
    logic [OFF_W-1:0]   off_z_q      = '0;
    logic               inv_gy_q     = 1'b0;

    // predictor copy of the deframer and filter state
    bit          in_sync     = 1'b0;
    int          hunt_zeros  = 0;
    int          pos         = 0;
    bit          trailer_ok  = 1'b1;
    logic [7:0]  frame_bytes [STORE_LEN];
    logic [31:0] filt [NCH] = '{default: 32'h0};

    function automatic longint sat32(input longint v);
        if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
        if (v < -longint'(64'sh80000000)) return -longint'(64'sh80000000);
        return v;
    endfunction

    // one filter step: q16.16 state, q1.16 weight of the new sample, round half up
    function automatic logic [31:0] smooth(input logic [31:0] old, input longint smp,
                                           input logic [RATIO_W-1:0] ratio);
        longint s;
        longint r;
        longint acc;
        s   = sat32(smp * (longint'(1) << FRAC_BITS_DEF));
        r   = (ratio > RATIO_ONE) ? longint'(RATIO_ONE) : longint'(ratio);
        acc = s * r + longint'($signed(old)) * (longint'(RATIO_ONE) - r) + ROUND_HALF;
        return 32'(sat32(acc >>> RATIO_FRAC));
    endfunction

    // gyro: bits 25..10 of a big-endian word, signed 16 bit
    function automatic longint gyro_word(input int p);
        logic [31:0] w;
        logic [15:0] g;
        w = {frame_bytes[p], frame_bytes[p+1], frame_bytes[p+2], frame_bytes[p+3]};
        g = w[GYRO_MSB:GYRO_LSB];
        return longint'($signed(g));
    endfunction

    // accel: big-endian word minus offset, floor divide by four
    function automatic longint accel_word(input int p, input logic [OFF_W-1:0] off);
        logic [15:0] a;
        a = {frame_bytes[p], frame_bytes[p+1]};
        return (longint'(a) - longint'(off)) >>> ACC_SHIFT;
    endfunction

    // advance the deframer by one accepted byte, queue a result at frame end
    function automatic void deframe_byte(input logic [7:0] b);
        t_imu_result res;
        t_fixed_res  fixed;
        longint      gy;
        if (!in_sync) begin
            if (b != 8'h00) hunt_zeros = 0;
            else if (hunt_zeros < 7) hunt_zeros++;
            if (hunt_zeros >= SYNC_RUN) begin
                in_sync    = 1'b1;
                hunt_zeros = 0;
                pos        = 0;
                trailer_ok = 1'b1;
            end
            return;
        end
        if (pos < STORE_LEN) frame_bytes[pos] = b;
        else if (b != 8'h00) trailer_ok = 1'b0;
        if (pos < FRAME_LEN - 1) begin
            pos++;
            return;
        end
        pos = 0;
        if (!trailer_ok) begin
            // dirty trailer: status only, filters untouched, back to hunting
            in_sync    = 1'b0;
            hunt_zeros = 0;
            trailer_ok = 1'b1;
            res        = DIRTY_RES;
        end else begin
            gy = gyro_word(4);
            if (inv_gy_q) gy = -gy;
            filt[0] = smooth(filt[0], accel_word(12, off_x_q), acc_ratio_q);
            filt[1] = smooth(filt[1], accel_word(14, off_y_q), acc_ratio_q);
            filt[2] = smooth(filt[2], accel_word(16, off_z_q), acc_ratio_q);
            filt[3] = smooth(filt[3], gyro_word(0), gyro_ratio_q);
            filt[4] = smooth(filt[4], gy, gyro_ratio_q);
            filt[5] = smooth(filt[5], gyro_word(8), gyro_ratio_q);
            trailer_ok = 1'b1;
            res = '{1'b0, filt[0], filt[1], filt[2], filt[3], filt[4], filt[5]};
        end
        // directed rows may carry a value typed in by hand
        if (fixed_q.size() != 0) begin
            fixed = fixed_q.pop_front();
            if (fixed.on) res = fixed.res;
        end
        expected_frames.push_back(res);
    endfunction

    // byte sender: bursts of random length with random gaps between them
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (stim_bytes.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= stim_bytes.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver: stall rate redrawn periodically, from none to heavy
    int stall_pct = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (cycle_count % 64 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct <= 0;
                    2:       stall_pct <= 30;
                    3:       stall_pct <= 60;
                    default: stall_pct <= 95;
                endcase
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // every result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_imu_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_frames.size() == 0) begin
                $error("result beat with no expectation pending");
                fail_count++;
            end else begin
                want = expected_frames.pop_front();
                cmp_field("frame_status", 32'(want.status), 32'(m_axis_tuser));
                cmp_field("filt_acc_a",  want.acc_a,  m_axis_tdata[31:0]);
                cmp_field("filt_acc_b",  want.acc_b,  m_axis_tdata[63:32]);
                cmp_field("filt_acc_c",  want.acc_c,  m_axis_tdata[95:64]);
                cmp_field("filt_gyro_x", want.gyro_x, m_axis_tdata[127:96]);
                cmp_field("filt_gyro_y", want.gyro_y, m_axis_tdata[159:128]);
                cmp_field("filt_gyro_z", want.gyro_z, m_axis_tdata[191:160]);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("imu_frame_deframe_filter_core test failed");
            $finish;
        end
    end

    // wait until every byte is taken and every result has come back
    task automatic drain();
        while (stim_bytes.size() != 0 || s_axis_tvalid || expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
    endtask

    // write the whole register set plus the two unused addresses
    task automatic load_regs(input t_reg_set rs);
        put_reg(CFG_ACC_RATIO,  rs.acc_ratio);
        put_reg(CFG_GYRO_RATIO, rs.gyro_ratio);
        put_reg(CFG_OFFSET_X,   CFG_DW'(rs.off_x));
        put_reg(CFG_OFFSET_Y,   CFG_DW'(rs.off_y));
        put_reg(CFG_OFFSET_Z,   CFG_DW'(rs.off_z));
        put_reg(CFG_INVERT_GY,  CFG_DW'(rs.inv_gy));
        put_reg(CFG_SPARE_LO,   {CFG_DW{1'b1}});
        put_reg(CFG_SPARE_HI,   {CFG_DW{1'b1}});
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        acc_ratio_q  = rs.acc_ratio;
        gyro_ratio_q = rs.gyro_ratio;
        off_x_q      = rs.off_x;
        off_y_q      = rs.off_y;
        off_z_q      = rs.off_z;
        inv_gy_q     = rs.inv_gy;
    endtask

    function automatic logic [RATIO_W-1:0] pick_ratio();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return RATIO_ONE;
            2:       return RATIO_W'($urandom_range(32'h10001, 32'h1FFFF));
            default: return RATIO_W'($urandom_range(0, 32'h10000));
        endcase
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return OFF_W'($urandom());
        endcase
    endfunction

    initial begin
        t_frame_row row;
        t_reg_set   rs;
        bit         gen_hunting;
        bit         dirty;
        int         n_bytes;
        int         run;
        int         k;
        int         dpos;
        int         r;
        logic [7:0] b;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        foreach (DIR_ROWS[i]) begin
            row = DIR_ROWS[i];
            if (row.cfg_en) begin
                drain();
                load_regs(row.regs);
            end
            if (row.lead == LEAD_NOISY) begin
                repeat (SYNC_RUN - 1) stim_bytes.push_back(8'h00);
                stim_bytes.push_back(8'h5A);
            end
            if (row.lead != LEAD_NONE) begin
                repeat (SYNC_RUN) stim_bytes.push_back(8'h00);
            end
            for (int j = 0; j < STORE_LEN; j++) stim_bytes.push_back(row.payload[j]);
            for (int j = 0; j < 4; j++) stim_bytes.push_back(row.trailer[j]);
            fixed_q.push_back('{row.has_exp, row.exp_res});
        end
        drain();
        gen_hunting = !in_sync;

        // random frame streams, one register setting per phase
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) drain();
            rs.acc_ratio  = pick_ratio();
            rs.gyro_ratio = pick_ratio();
            rs.off_x      = pick_offset();
            rs.off_y      = pick_offset();
            rs.off_z      = pick_offset();
            rs.inv_gy     = 1'($urandom_range(0, 1));
            load_regs(rs);
            n_bytes = 0;
            while (n_bytes < PHASE_BYTES) begin
                if (gen_hunting) begin
                    // line noise with short zero runs, always ends on a nonzero byte
                    if ($urandom_range(0, 1) == 1) begin
                        k   = $urandom_range(1, 8);
                        run = 0;
                        for (int j = 0; j < k; j++) begin
                            if (j == k - 1 || run == SYNC_RUN - 1 || $urandom_range(0, 2) != 0)
                                b = 8'($urandom_range(1, 255));
                            else
                                b = 8'h00;
                            run = (b == 8'h00) ? run + 1 : 0;
                            stim_bytes.push_back(b);
                            n_bytes++;
                        end
                    end
                    repeat (SYNC_RUN) stim_bytes.push_back(8'h00);
                    n_bytes += SYNC_RUN;
                    gen_hunting = 1'b0;
                end
                for (int j = 0; j < STORE_LEN; j++) begin
                    r = $urandom_range(0, 7);
                    b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                    stim_bytes.push_back(b);
                end
                // one frame in eight gets a dirty trailer
                dirty = ($urandom_range(0, 7) == 0);
                dpos  = $urandom_range(0, 3);
                for (int j = 0; j < 4; j++) begin
                    b = 8'h00;
                    if (dirty && (j == dpos || $urandom_range(0, 3) == 0))
                        b = 8'($urandom_range(1, 255));
                    stim_bytes.push_back(b);
                end
                if (dirty) gen_hunting = 1'b1;
                n_bytes += FRAME_LEN;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_frames.size() == 0) begin
            $display("imu_frame_deframe_filter_core test passed");
        end else begin
            $display("imu_frame_deframe_filter_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
